// File: rtl/core/char_sequence_table_engine_assert.svh
// Assertion macros used by the engine.
`ifndef CHAR_SEQUENCE_TABLE_ENGINE_ASSERT_SVH
`define CHAR_SEQUENCE_TABLE_ENGINE_ASSERT_SVH

// Checks that an implication holds on every clock edge outside reset.
`define CSTE_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an implication holds in the cycle after the antecedent.
`define CSTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cste_pkg.sv
package cste_pkg;

    localparam int unsigned AW = 6;
    localparam int unsigned CW = 7;

    localparam logic [3:0] REQ_CLEAR   = 4'd0;
    localparam logic [3:0] REQ_APPEND  = 4'd1;
    localparam logic [3:0] REQ_INSERT  = 4'd2;
    localparam logic [3:0] REQ_DELETE  = 4'd3;
    localparam logic [3:0] REQ_MODIFY  = 4'd4;
    localparam logic [3:0] REQ_READ    = 4'd5;
    localparam logic [3:0] REQ_FIND    = 4'd6;
    localparam logic [3:0] REQ_MIN     = 4'd7;
    localparam logic [3:0] REQ_BSEARCH = 4'd8;
    localparam logic [3:0] REQ_SORT    = 4'd9;
    localparam logic [3:0] REQ_EMIT    = 4'd10;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [3:0]        req_type;
        logic [5:0]        position;
        logic [5:0]        range_low;
        logic [5:0]        range_high;
        logic signed [7:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        index_out;
        logic signed [7:0] char_out;
        logic [6:0]        count_out;
        logic              last;
    } rsp_t;

endpackage

// File: rtl/core/char_sequence_table_engine.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | cste_pkg::req_t
// rsp     | out       | rsp_valid/rsp_ready | cste_pkg::rsp_t
// Each request passes through a sequencer around one RAM with a registered read and one
// compare unit. Insert, delete, find, min and emit walk the entries one at a time, bsearch
// halves its range at each step, and sort repeats a minimum search and swap for each
// outer slot. Reset empties the sequence at once, the RAM needs no clearing. A stalled
// result holds the sequencer, and a new request is taken only once the previous result
// has been accepted.
module char_sequence_table_engine #(
    parameter int CAPACITY = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  cste_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output cste_pkg::rsp_t  rsp
);
    import cste_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_WAIT  = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_WR    = 9'b000010000,
        S_SWRD  = 9'b000100000,
        S_SWW1  = 9'b001000000,
        S_SWW2  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     i_reg, i_next;        // walk index
    logic [CW-1:0]     j_reg, j_next;        // sort outer index
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW:0]       l_reg, l_next, r_reg, r_next;
    logic [CW-1:0]     best_reg, best_next;
    logic signed [7:0] m_reg, m_next;
    logic signed [7:0] t_reg, t_next;
    logic              emit_reg, emit_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rv_reg, rv_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic signed [7:0] rd;
    logic [CW-1:0] cap;
    logic [CW-1:0] mid;

    assign cap = CW'(CAPACITY);
    assign rd  = signed'(rdata);
    assign mid = CW'((l_reg + r_reg) >> 1);

    cste_ram #(.WIDTH(8), .DEPTH(64)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // The result register doubles as the working result, so a new request waits
    // until the previous result has left.
    assign req_ready = (state_reg == S_IDLE) && !rv_reg;
    assign rsp_valid = rv_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        hi_next     = hi_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        best_next   = best_reg;
        m_next      = m_reg;
        t_next      = t_reg;
        emit_next   = emit_reg;
        rsp_next    = rsp_reg;
        rv_next     = rv_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        raddr       = AW'(i_reg);

        if (rv_reg && rsp_ready)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    req_next  = req;
                    emit_next = 1'b0;
                    rsp_next  = '{status: ST_DONE, index_out: '0, char_out: '0,
                                  count_out: count_reg, last: 1'b1};
                    hi_next   = (CW'(req.range_high) >= count_reg) ? count_reg - 1'b1
                                                                   : CW'(req.range_high);
                    state_next = S_OUT;
                    case (req.req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            rsp_next.count_out = '0;
                        end
                        REQ_APPEND:
                        begin
                            if (count_reg < cap)
                            begin
                                we = 1'b1;
                                waddr = AW'(count_reg);
                                wdata = req.value;
                                count_next = count_reg + 1'b1;
                                rsp_next.count_out = count_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = ST_IGNORED;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (count_reg < cap && CW'(req.position) <= count_reg)
                            begin
                                i_next = count_reg;
                                state_next = S_RD;
                            end
                            else
                            begin
                                rsp_next.status = ST_IGNORED;
                            end
                        end
                        REQ_DELETE, REQ_MODIFY, REQ_READ:
                        begin
                            if (CW'(req.position) < count_reg)
                            begin
                                i_next = CW'(req.position);
                                state_next = S_RD;
                            end
                            else
                            begin
                                rsp_next.status = ST_IGNORED;
                            end
                        end
                        REQ_FIND, REQ_MIN:
                        begin
                            if (CW'(req.range_low) >= count_reg ||
                                CW'(req.range_low) > hi_next)
                            begin
                                rsp_next.status = (req.req_type == REQ_FIND &&
                                    CW'(req.range_low) < count_reg) ? ST_NOTFOUND
                                                                     : ST_IGNORED;
                            end
                            else
                            begin
                                i_next = CW'(req.range_low);
                                best_next = CW'(req.range_low);
                                rsp_next.status = (req.req_type == REQ_FIND) ? ST_NOTFOUND
                                                                             : ST_DONE;
                                state_next = S_RD;
                            end
                        end
                        REQ_BSEARCH:
                        begin
                            rsp_next.status = ST_NOTFOUND;
                            l_next = '0;
                            r_next = {1'b0, count_reg} - 1'b1;
                            if (count_reg != '0)
                            begin
                                i_next = CW'(({1'b0, count_reg} - 1'b1) >> 1);
                                state_next = S_RD;
                            end
                        end
                        REQ_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                j_next = '0;
                                i_next = '0;
                                best_next = '0;
                                hi_next = count_reg - 1'b1;
                                state_next = S_RD;
                            end
                        end
                        REQ_EMIT:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                i_next = '0;
                                emit_next = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_IGNORED;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                // Address for the walk element; data comes back next cycle.
                case (req_reg.req_type)
                    REQ_INSERT: raddr = AW'(i_reg - 1'b1);
                    REQ_DELETE: raddr = AW'(i_reg + 1'b1);
                    default:    raddr = AW'(i_reg);
                endcase
                state_next = S_EVAL;
                if (req_reg.req_type == REQ_INSERT && i_reg == CW'(req_reg.position))
                begin
                    state_next = S_WR;
                end
                if (req_reg.req_type == REQ_DELETE && i_reg + 1'b1 >= count_reg)
                begin
                    state_next = S_WR;
                end
                if (req_reg.req_type == REQ_MODIFY)
                begin
                    state_next = S_WR;
                end
            end

            S_EVAL:
            begin
                case (req_reg.req_type)
                    REQ_INSERT:
                    begin
                        we = 1'b1; waddr = AW'(i_reg); wdata = rdata;
                        i_next = i_reg - 1'b1;
                        state_next = S_RD;
                    end
                    REQ_DELETE:
                    begin
                        we = 1'b1; waddr = AW'(i_reg); wdata = rdata;
                        i_next = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                    REQ_READ:
                    begin
                        rsp_next.char_out = rd;
                        state_next = S_OUT;
                    end
                    REQ_FIND:
                    begin
                        if (rd == req_reg.value)
                        begin
                            rsp_next.status = ST_DONE;
                            rsp_next.index_out = AW'(i_reg);
                            state_next = S_OUT;
                        end
                        else if (i_reg >= hi_reg)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    REQ_MIN:
                    begin
                        if (i_reg == best_reg || rd < m_reg)
                        begin
                            m_next = rd;
                            best_next = i_reg;
                            rsp_next.index_out = AW'(i_reg);
                        end
                        if (i_reg >= hi_reg)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    REQ_BSEARCH:
                    begin
                        if (rd == req_reg.value)
                        begin
                            rsp_next.status = ST_DONE;
                            rsp_next.index_out = AW'(mid);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            if (req_reg.value < rd)
                            begin
                                r_next = {1'b0, mid} - 1'b1;
                            end
                            else
                            begin
                                l_next = {1'b0, mid} + 1'b1;
                            end
                            state_next = S_WAIT;
                        end
                    end
                    REQ_SORT:
                    begin
                        if (i_reg == j_reg || rd < m_reg)
                        begin
                            m_next = rd;
                            best_next = i_reg;
                        end
                        if (i_reg == j_reg)
                        begin
                            t_next = rd;
                        end
                        if (i_reg >= hi_reg)
                        begin
                            state_next = S_SWW1;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    REQ_EMIT:
                    begin
                        if (!rv_reg || rsp_ready)
                        begin
                            rv_next = 1'b1;
                            rsp_next = '{status: ST_DONE, index_out: AW'(i_reg),
                                         char_out: rd, count_out: count_reg,
                                         last: (i_reg + 1'b1 == count_reg)};
                            if (i_reg + 1'b1 == count_reg)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                i_next = i_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_WAIT:
            begin
                // Binary search bounds update settles here.
                if ($signed(l_reg) > $signed(r_reg))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    i_next = mid;
                    state_next = S_RD;
                end
            end

            S_WR:
            begin
                case (req_reg.req_type)
                    REQ_INSERT:
                    begin
                        we = 1'b1; waddr = AW'(req_reg.position); wdata = req_reg.value;
                        count_next = count_reg + 1'b1;
                        rsp_next.count_out = count_reg + 1'b1;
                    end
                    REQ_DELETE:
                    begin
                        count_next = count_reg - 1'b1;
                        rsp_next.count_out = count_reg - 1'b1;
                    end
                    REQ_MODIFY:
                    begin
                        we = 1'b1; waddr = AW'(req_reg.position); wdata = req_reg.value;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_OUT;
            end

            S_SWRD:
            begin
                state_next = S_SWW1;
            end

            S_SWW1:
            begin
                // Swap: minimum goes to the outer slot, old outer value to its place.
                we = 1'b1; waddr = AW'(j_reg); wdata = m_reg;
                state_next = S_SWW2;
            end

            S_SWW2:
            begin
                we = 1'b1; waddr = AW'(best_reg); wdata = t_reg;
                if (j_reg + 1'b1 >= hi_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    i_next = j_reg + 1'b1;
                    best_next = j_reg + 1'b1;
                    state_next = S_RD;
                end
            end

            S_OUT:
            begin
                if (!rv_reg || rsp_ready)
                begin
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        hi_reg     <= hi_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        best_reg   <= best_next;
        m_reg      <= m_next;
        t_reg      <= t_next;
        emit_reg   <= emit_next;
        rsp_reg    <= rsp_next;
    end

`include "char_sequence_table_engine_assert.svh"

    `CSTE_ASSERT(a_count_cap, 1'b1, count_reg <= cap, "fill count above capacity")
    `CSTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
        "stalled result changed")
    `CSTE_ASSERT(a_last_idle, rsp_valid && rsp_ready && rsp.last && !emit_reg,
        state_reg == S_IDLE, "final result while the sequencer is busy")

endmodule

// File: rtl/core/cste_ram.sv
module cste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
